// ===== rtl/dfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package dfr_pkg;

    localparam int unsigned CfgIndexWidth = 4;
    localparam int unsigned CfgDataWidth  = 64;

    // Register indexes of the configuration port
    localparam logic [CfgIndexWidth-1:0] REG_FRAME_MAGIC      = 4'd0;
    localparam logic [CfgIndexWidth-1:0] REG_PROTOCOL_VERSION = 4'd1;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_BODY_LENGTH  = 4'd2;
    localparam logic [CfgIndexWidth-1:0] REG_KNOWN_TYPE_MASK  = 4'd3;

    // Register reset values
    localparam logic [15:0] MAGIC_RESET     = 16'h0000;
    localparam logic [7:0]  VERSION_RESET   = 8'h00;
    localparam logic [31:0] MAX_LEN_RESET   = 32'h0000_FFFF;
    localparam logic [63:0] TYPE_MASK_RESET = 64'h0000_0000_0000_01FE;

    // Result kinds
    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Last header byte position (eight bytes, counted from zero)
    localparam logic [2:0] HDR_LAST_POS = 3'd7;

    typedef struct packed {
        logic [15:0] frame_magic;
        logic [7:0]  protocol_version;
        logic [31:0] max_body_length;
        logic [63:0] known_type_mask;
    } dfr_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] body_byte;
        logic       last;
    } dfr_result_t;

    typedef struct packed {
        logic halted;
        logic in_body;
    } dfr_status_t;

endpackage

`default_nettype wire

// ===== rtl/dfr_cfg.sv =====
// Configuration register bank of the frame deframer.
// Depends on dfr_pkg for register indexes, reset values and dfr_cfg_t.
`default_nettype none

module dfr_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dfr_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [dfr_pkg::CfgDataWidth-1:0]  cfg_data,
    output dfr_pkg::dfr_cfg_t                      cfg
);
    import dfr_pkg::*;

    dfr_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_magic      <= MAGIC_RESET;
            cfg_reg.protocol_version <= VERSION_RESET;
            cfg_reg.max_body_length  <= MAX_LEN_RESET;
            cfg_reg.known_type_mask  <= TYPE_MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            // Drop writes to unmapped indexes
            unique case (cfg_index)
                REG_FRAME_MAGIC:      cfg_reg.frame_magic      <= cfg_data[15:0];
                REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= cfg_data[7:0];
                REG_MAX_BODY_LENGTH:  cfg_reg.max_body_length  <= cfg_data[31:0];
                REG_KNOWN_TYPE_MASK:  cfg_reg.known_type_mask  <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/dfr_core.sv =====
// Parser state and per-byte decision logic of the frame deframer.
// Depends on dfr_pkg for configuration, result and status types.
`default_nettype none

module dfr_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         in_byte,
    input  wire dfr_pkg::dfr_cfg_t  cfg,
    output logic                    res_valid,
    output dfr_pkg::dfr_result_t    res,
    output dfr_pkg::dfr_status_t    status
);
    import dfr_pkg::*;

    logic        halted_reg,  halted_next;
    logic        in_body_reg, in_body_next;
    logic [2:0]  pos_reg,     pos_next;
    logic [55:0] store_reg,   store_next;
    logic [7:0]  type_reg,    type_next;
    logic [31:0] remain_reg,  remain_next;

    logic [15:0] hdr_magic;
    logic [7:0]  hdr_version;
    logic [7:0]  hdr_type;
    logic [31:0] hdr_length;
    logic        type_known;
    logic        hdr_bad;
    logic        body_last;

    assign hdr_magic   = store_reg[55:40];
    assign hdr_version = store_reg[39:32];
    assign hdr_type    = store_reg[31:24];
    assign hdr_length  = {store_reg[23:0], in_byte};
    assign type_known  = (hdr_type[7:6] == 2'b00) && cfg.known_type_mask[hdr_type[5:0]];
    assign hdr_bad     = (hdr_magic != cfg.frame_magic)
                      || (hdr_version != cfg.protocol_version)
                      || !type_known
                      || (hdr_length > cfg.max_body_length);
    assign body_last   = (remain_reg <= 32'd1);

    always_comb
    begin
        halted_next  = halted_reg;
        in_body_next = in_body_reg;
        pos_next     = pos_reg;
        store_next   = store_reg;
        type_next    = type_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '{kind: KIND_BODY, frame_type: type_reg, body_byte: 8'h00, last: 1'b0};

        if (accept && !halted_reg)
        begin
            if (in_body_reg)
            begin
                res_valid     = 1'b1;
                res.body_byte = in_byte;
                res.last      = body_last;
                remain_next   = remain_reg - 32'd1;
                if (body_last)
                begin
                    remain_next  = 32'd0;
                    in_body_next = 1'b0;
                end
            end
            else if (pos_reg != HDR_LAST_POS)
            begin
                store_next = {store_reg[47:0], in_byte};
                pos_next   = pos_reg + 3'd1;
            end
            else
            begin
                pos_next       = 3'd0;
                store_next     = 56'd0;
                res.frame_type = hdr_type;
                if (hdr_bad)
                begin
                    halted_next = 1'b1;
                    res_valid   = 1'b1;
                    res.kind    = KIND_ERROR;
                end
                else
                begin
                    type_next = hdr_type;
                    if (hdr_length == 32'd0)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_EMPTY;
                        res.last  = 1'b1;
                    end
                    else
                    begin
                        remain_next  = hdr_length;
                        in_body_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg  <= 1'b0;
            in_body_reg <= 1'b0;
            pos_reg     <= 3'd0;
            store_reg   <= 56'd0;
            type_reg    <= 8'd0;
            remain_reg  <= 32'd0;
        end
        else
        begin
            halted_reg  <= halted_next;
            in_body_reg <= in_body_next;
            pos_reg     <= pos_next;
            store_reg   <= store_next;
            type_reg    <= type_next;
            remain_reg  <= remain_next;
        end
    end

    assign status = '{halted: halted_reg, in_body: in_body_reg};

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer: config bank, parser, result register.
// Depends on dfr_pkg, dfr_cfg and dfr_core.
`default_nettype none

// Takes one received byte per transfer and parses 8-byte big-endian headers
// (16-bit magic, version byte, type byte, 32-bit body length). On the eighth
// header byte the header is checked against frame_magic, protocol_version,
// known_type_mask (types 64 and above are never known) and max_body_length.
// A failed check yields one error result (kind 2) and the block then drops
// every byte until reset. A good header with zero length yields one
// empty-frame result (kind 1, last set); otherwise each body byte comes out
// as kind 0 with the frame type and last set on the final byte. Header bytes
// give no result. Rate: one byte per clock cycle, with each result loaded
// into the output register by the transfer that makes it; the parser decides each
// byte in one pass from its state registers, and the only thing that holds
// the input is a full result register that downstream stalls. The user must
// write configuration through cfg_wr_en/cfg_index/cfg_data only while the
// block is idle, which the block does not enforce. Writes above index three are ignored.
module length_prefixed_frame_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dfr_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [dfr_pkg::CfgDataWidth-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        in_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             result_kind,
    output logic [7:0]                             frame_type,
    output logic [7:0]                             body_byte,
    output logic                                   last_of_frame
);
    import dfr_pkg::*;

    dfr_cfg_t    cfg;
    dfr_result_t res;
    dfr_status_t status;
    logic        res_valid;
    logic        in_xfer;
    logic        out_xfer;

    logic        out_valid_reg, out_valid_next;
    dfr_result_t out_reg;

    // Hold the input only while a finished result waits downstream
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    dfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .in_byte   (in_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // Result register: load a new result, or drop the valid once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; advance only when a result is produced
    always_ff @(posedge clk)
    begin
        if (in_xfer && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign frame_type    = out_reg.frame_type;
    assign body_byte     = out_reg.body_byte;
    assign last_of_frame = out_reg.last;

    // A halted parser never produces another result
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        status.halted |-> !res_valid)
        else $error("result produced after header error");

    // An error result halts the parser at the next edge
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && res_valid && res.kind == KIND_ERROR) |=> status.halted)
        else $error("header error did not halt parser");

    // A new result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(in_xfer && res_valid))
        else $error("pending result overwritten");

    // Empty frames always carry the last flag; errors never do
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((result_kind == KIND_EMPTY && last_of_frame)
                        || (result_kind == KIND_ERROR && !last_of_frame)
                        || (result_kind == KIND_BODY)))
        else $error("last flag inconsistent with result kind");

    // Headers are only checked outside a body, so halt and body never overlap
    a_halt_not_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.halted && status.in_body))
        else $error("parser halted inside a frame body");

endmodule

`default_nettype wire
